// File: hw/rtl/dpd_pkg.sv
package dpd_pkg;

  localparam int unsigned BufferDepth = 1024;
  localparam int unsigned FillW = $clog2(BufferDepth);

  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChBreak   = 8'h03;
  localparam logic [7:0] ChNull    = 8'h00;

  typedef enum logic [3:0] {
    EvNone     = 4'd0,
    EvPayload  = 4'd1,
    EvDone     = 4'd2,
    EvOverflow = 4'd3,
    EvAck      = 4'd4,
    EvReplay   = 4'd5,
    EvBreak    = 4'd6,
    EvNotify   = 4'd7,
    EvSkipped  = 4'd8
  } event_kind_e;

  typedef struct packed {
    event_kind_e      kind;
    logic [7:0]       payload_byte;
    logic [FillW-1:0] payload_index;
    logic [FillW-1:0] packet_length;
    logic [7:0]       sum_char_high;
    logic [7:0]       sum_char_low;
  } result_t;

endpackage

// File: hw/rtl/debug_packet_deframer_core.sv
// Packet deframer for the debugger remote serial protocol: one received byte
// goes in per transfer and exactly one event comes out for it, in order.
// The framing logic is combinational and its result goes into the output
// register, so a byte can be taken every cycle while input ready is high;
// a two-entry output buffer keeps input ready high until its skid entry fills.
// Payloads hold at most 1023 bytes; a longer one yields an overflow event.
module debug_packet_deframer_core
  import dpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] event_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [9:0] payload_index_o,
  output logic [9:0] packet_length_o,
  output logic [7:0] sum_char_high_o,
  output logic [7:0] sum_char_low_o
);

  logic    in_fire;
  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  dpd_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_fire),
    .rx_byte_i (rx_byte_i),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = out_q.kind;
  assign payload_byte_o  = out_q.payload_byte;
  assign payload_index_o = out_q.payload_index;
  assign packet_length_o = out_q.packet_length;
  assign sum_char_high_o = out_q.sum_char_high;
  assign sum_char_low_o  = out_q.sum_char_low;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  a_payload_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != EvPayload
      |-> payload_byte_o == 8'd0 && payload_index_o == 10'd0)
    else $error("payload fields set on non-payload event");

endmodule

// File: hw/rtl/dpd_frame.sv
module dpd_frame
  import dpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output result_t    result_o
);

  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhPayload = 2'd1;
  localparam logic [1:0] PhHash    = 2'd2;
  localparam logic [1:0] PhSum1    = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       sum_high_q, sum_high_d;
  logic [7:0]       sum_low_q, sum_low_d;
  result_t          res;

  always_comb begin
    phase_d    = phase_q;
    fill_d     = fill_q;
    sum_high_d = sum_high_q;
    sum_low_d  = sum_low_q;
    res        = '0;
    res.kind   = EvNone;
    unique case (phase_q)
      PhPayload: begin
        if (rx_byte_i == ChHash) begin
          phase_d = PhHash;
        end else if (fill_q < FillW'(BufferDepth - 1)) begin
          res.kind          = EvPayload;
          res.payload_byte  = rx_byte_i;
          res.payload_index = fill_q;
          fill_d            = fill_q + FillW'(1);
        end else begin
          res.kind = EvOverflow;
          fill_d   = '0;
          phase_d  = PhIdle;
        end
      end
      PhHash: begin
        sum_high_d = rx_byte_i;
        phase_d    = PhSum1;
      end
      PhSum1: begin
        sum_low_d         = rx_byte_i;
        phase_d           = PhIdle;
        res.kind          = EvDone;
        res.packet_length = fill_q;
        res.sum_char_high = sum_high_q;
        res.sum_char_low  = rx_byte_i;
      end
      PhIdle: begin
        priority if (rx_byte_i == ChDollar) begin
          fill_d  = '0;
          phase_d = PhPayload;
        end else if (rx_byte_i == ChPercent) begin
          res.kind = EvNotify;
        end else if (rx_byte_i == ChPlus) begin
          res.kind = EvAck;
        end else if (rx_byte_i == ChMinus) begin
          res.kind          = EvReplay;
          res.packet_length = fill_q;
          res.sum_char_high = sum_high_q;
          res.sum_char_low  = sum_low_q;
        end else if (rx_byte_i == ChBreak) begin
          res.kind = EvBreak;
        end else if (rx_byte_i != ChNull) begin
          res.kind = EvSkipped;
        end else begin
          res.kind = EvNone;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      fill_q     <= '0;
      sum_high_q <= '0;
      sum_low_q  <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      fill_q     <= fill_d;
      sum_high_q <= sum_high_d;
      sum_low_q  <= sum_low_d;
    end
  end

  assign result_o = res;

  a_overflow_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PhPayload && rx_byte_i != ChHash
      && fill_q == FillW'(BufferDepth - 1)
      |=> phase_q == PhIdle && fill_q == '0)
    else $error("overflow did not return between packets");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PhIdle && rx_byte_i == ChDollar
      |=> phase_q == PhPayload && fill_q == '0)
    else $error("packet start did not enter payload");

endmodule
